@@ hw/rtl/upi_pkg.sv @@
// Shared types, constants and tables for the unicycle pose integrator.
package upi_pkg;

  // CORDIC datapath widths: x/y in Q2.30 with headroom, residual angle in 2^-32 turn
  localparam int CW = 34;
  localparam int ZW = 33;
  localparam int ATAN_ENTRIES = 24;
  localparam int AIW = 5;

  localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [CW-1:0] RAD_TO_TURN_Q28 = 34'sd683565276;
  localparam logic signed [31:0]   POS_RESET       = 32'sd32768;

  typedef struct packed {
    logic signed [15:0] forward_speed;
    logic signed [15:0] turn_rate;
    logic        [15:0] elapsed_time;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [31:0] heading_turns;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } out_req_t;

  typedef enum logic [2:0] {
    MUL_D = 3'd0,
    MUL_W = 3'd1,
    MUL_K = 3'd2,
    MUL_X = 3'd3,
    MUL_Y = 3'd4
  } mul_sel_e;

  typedef struct packed {
    logic     load_in;
    logic     cordic_start;
    logic     cordic_half;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     dh_en;
    logic     add_x;
    logic     add_y;
    logic     head_en;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic cordic_busy;
  } sts_t;

  // atan(2^-i) in 2^-32 turn
  function automatic logic [31:0] atan_turns(input logic [AIW-1:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:    r = 32'd536870912;
      5'd1:    r = 32'd316933406;
      5'd2:    r = 32'd167458907;
      5'd3:    r = 32'd85004756;
      5'd4:    r = 32'd42667331;
      5'd5:    r = 32'd21354465;
      5'd6:    r = 32'd10679838;
      5'd7:    r = 32'd5340245;
      5'd8:    r = 32'd2670163;
      5'd9:    r = 32'd1335087;
      5'd10:   r = 32'd667544;
      5'd11:   r = 32'd333772;
      5'd12:   r = 32'd166886;
      5'd13:   r = 32'd83443;
      5'd14:   r = 32'd41722;
      5'd15:   r = 32'd20861;
      5'd16:   r = 32'd10430;
      5'd17:   r = 32'd5215;
      5'd18:   r = 32'd2608;
      5'd19:   r = 32'd1304;
      5'd20:   r = 32'd652;
      5'd21:   r = 32'd326;
      5'd22:   r = 32'd163;
      5'd23:   r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/unicycle_pose_integrator.sv @@
// Top level of the unicycle pose integrator (dead-reckoning odometry).
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_req_i) carries one tick request:
//   forward speed, turn rate and elapsed time. A request is taken on a rising edge
//   with in_valid_i high and in_stall_o low.
//   Output channel (out_valid_o / out_stall_i / out_req_o) carries one pose request
//   per tick: x, y (Q16.16, saturated), heading (2^-32 turn, wraps) and the yaw
//   quaternion pair (Q1.15).
// Sequencing:
//   A new tick is taken only once the last pose is in the output register.
//   The single iterative CORDIC sets the pace: one pass on the old heading
//   (overlapped with the speed/rate multiplies) and one on the new half
//   heading, one micro-rotation per cycle.
// Reset:
//   Pose returns to x = y = 0.5 m, heading 0; no result pending.
// Stall:
//   The result sits in an output register; the next tick is accepted and worked on
//   while it waits. A finished pose is held back until the register frees up.
module unicycle_pose_integrator #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  upi_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output upi_pkg::out_req_t out_req_o
);

  upi_pkg::cmd_t cmd;
  upi_pkg::sts_t sts;

  // sequencer
  upi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // arithmetic, pose state and result register
  upi_dp #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .in_req_i (in_req_i),
    .out_req_o(out_req_o)
  );

endmodule

@@ hw/rtl/upi_cordic.sv @@
// Iterative rotation-mode CORDIC: sine and cosine of an angle in 2^-32 turn.
module upi_cordic #(
  parameter int STAGES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [31:0]                   angle_i,
  output logic                          busy_o,
  output logic signed [upi_pkg::CW-1:0] sin_o,
  output logic signed [upi_pkg::CW-1:0] cos_o
);

  localparam int IW = $clog2(STAGES);

  logic                          busy_q, busy_d;
  logic [IW-1:0]                 iter_q, iter_d;
  logic                          flip_q, flip_d;
  logic signed [upi_pkg::CW-1:0] x_q, x_d, y_q, y_d;
  logic signed [upi_pkg::ZW-1:0] z_q, z_d;
  logic signed [upi_pkg::CW-1:0] xs, ys;
  logic signed [upi_pkg::ZW-1:0] at;
  logic [31:0]                   a_red;
  logic                          flip_in;

  // quadrants 1 and 2 are folded by a half turn; both outputs are negated
  assign flip_in = (angle_i[31:30] == 2'b01) || (angle_i[31:30] == 2'b10);
  assign a_red   = flip_in ? (angle_i - 32'h8000_0000) : angle_i;

  assign xs = x_q >>> iter_q;
  assign ys = y_q >>> iter_q;
  assign at = $signed({1'b0, upi_pkg::atan_turns(upi_pkg::AIW'(iter_q))});

  always_comb begin
    busy_d = busy_q;
    iter_d = iter_q;
    flip_d = flip_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    if (start_i) begin
      busy_d = 1'b1;
      iter_d = '0;
      flip_d = flip_in;
      x_d    = upi_pkg::CORDIC_GAIN_Q30;
      y_d    = '0;
      z_d    = $signed({a_red[31], a_red});
    end else if (busy_q) begin
      if (!z_q[upi_pkg::ZW-1]) begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - at;
      end else begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + at;
      end
      if (iter_q == IW'(STAGES - 1)) begin
        busy_d = 1'b0;
      end else begin
        iter_d = iter_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    flip_q <= flip_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
  end

  assign busy_o = busy_q;
  assign cos_o  = flip_q ? -x_q : x_q;
  assign sin_o  = flip_q ? -y_q : y_q;

endmodule

@@ hw/rtl/upi_dp.sv @@
// Datapath: pose registers, shared multiplier, rounding/saturation, CORDIC, result register.
module upi_dp #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  upi_pkg::cmd_t     cmd_i,
  output upi_pkg::sts_t     sts_o,
  input  upi_pkg::in_req_t  in_req_i,
  output upi_pkg::out_req_t out_req_o
);

  upi_pkg::in_req_t  in_q;
  upi_pkg::out_req_t out_q;

  logic signed [31:0] x_q, y_q;
  logic [31:0]        heading_q;
  logic signed [31:0] d_q, wdt_q;
  logic signed [63:0] prod_q;
  logic [31:0]        dh_q;

  logic signed [31:0]             mul_a;
  logic signed [upi_pkg::CW-1:0]  mul_b;
  logic signed [65:0]             mul_p;
  logic signed [63:0]             rnd42, rnd27;
  logic signed [33:0]             pos_sum;
  logic signed [31:0]             pos_sat;
  logic signed [31:0]             pos_cur;
  logic                           cor_busy;
  logic signed [upi_pkg::CW-1:0]  cor_sin, cor_cos;
  logic [31:0]                    cor_angle;

  // round Q2.30 to Q1.15, half up, clamped
  function automatic logic signed [15:0] to_q15(input logic signed [upi_pkg::CW-1:0] v);
    logic signed [upi_pkg::CW-1:0] t;
    logic signed [upi_pkg::CW-16:0] r;
    logic signed [15:0] o;
    t = v + upi_pkg::CW'(34'sd16384);
    r = t[upi_pkg::CW-1:15];
    if (r > $signed(19'sd32767)) begin
      o = 16'sh7fff;
    end else if (r < $signed(-19'sd32768)) begin
      o = 16'sh8000;
    end else begin
      o = r[15:0];
    end
    return o;
  endfunction

  always_comb begin
    unique case (cmd_i.mul_sel)
      upi_pkg::MUL_D: begin
        mul_a = {{16{in_q.forward_speed[15]}}, in_q.forward_speed};
        mul_b = $signed({18'd0, in_q.elapsed_time});
      end
      upi_pkg::MUL_W: begin
        mul_a = {{16{in_q.turn_rate[15]}}, in_q.turn_rate};
        mul_b = $signed({18'd0, in_q.elapsed_time});
      end
      upi_pkg::MUL_K: begin
        mul_a = wdt_q;
        mul_b = upi_pkg::RAD_TO_TURN_Q28;
      end
      upi_pkg::MUL_X: begin
        mul_a = d_q;
        mul_b = cor_cos;
      end
      upi_pkg::MUL_Y: begin
        mul_a = d_q;
        mul_b = cor_sin;
      end
      default: begin
        mul_a = d_q;
        mul_b = cor_cos;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // d*trig is in 2^-58 m; back to Q16.16 with round half up
  assign rnd42   = prod_q + 64'sh0000_0200_0000_0000;
  assign rnd27   = prod_q + 64'sh0000_0000_0800_0000;
  assign pos_cur = cmd_i.add_y ? y_q : x_q;
  assign pos_sum = {{2{pos_cur[31]}}, pos_cur} + {{12{rnd42[63]}}, rnd42[63:42]};

  always_comb begin
    if (pos_sum > $signed(34'sh0_7fff_ffff)) begin
      pos_sat = 32'sh7fff_ffff;
    end else if (pos_sum < $signed(-34'sh0_8000_0000)) begin
      pos_sat = 32'sh8000_0000;
    end else begin
      pos_sat = pos_sum[31:0];
    end
  end

  assign cor_angle = cmd_i.cordic_half ? {1'b0, heading_q[31:1]} : heading_q;

  upi_cordic #(
    .STAGES(CORDIC_STAGES)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.cordic_start),
    .angle_i(cor_angle),
    .busy_o (cor_busy),
    .sin_o  (cor_sin),
    .cos_o  (cor_cos)
  );

  assign sts_o.cordic_busy = cor_busy;

  // pose state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q       <= upi_pkg::POS_RESET;
      y_q       <= upi_pkg::POS_RESET;
      heading_q <= '0;
    end else begin
      if (cmd_i.add_x) begin
        x_q <= pos_sat;
      end
      if (cmd_i.add_y) begin
        y_q <= pos_sat;
      end
      if (cmd_i.head_en) begin
        heading_q <= heading_q + dh_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_req_i;
    end
    if (cmd_i.mul_en) begin
      unique case (cmd_i.mul_sel)
        upi_pkg::MUL_D: d_q    <= mul_p[31:0];
        upi_pkg::MUL_W: wdt_q  <= mul_p[31:0];
        default:        prod_q <= mul_p[63:0];
      endcase
    end
    if (cmd_i.dh_en) begin
      dh_q <= rnd27[59:28];
    end
    if (cmd_i.load_out) begin
      out_q.pos_x         <= x_q;
      out_q.pos_y         <= y_q;
      out_q.heading_turns <= heading_q;
      out_q.quat_z        <= to_q15(cor_sin);
      out_q.quat_w        <= to_q15(cor_cos);
    end
  end

  assign out_req_o = out_q;

endmodule

@@ hw/rtl/upi_ctrl.sv @@
// Controller: one-hot sequencer over the pose update steps, plus output valid.
module upi_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  upi_pkg::sts_t sts_i,
  output upi_pkg::cmd_t cmd_o
);

  typedef enum logic [12:0] {
    ST_IDLE    = 13'b0_0000_0000_0001,
    ST_MUL_D   = 13'b0_0000_0000_0010,
    ST_MUL_W   = 13'b0_0000_0000_0100,
    ST_MUL_K   = 13'b0_0000_0000_1000,
    ST_DH      = 13'b0_0000_0001_0000,
    ST_WAIT_A  = 13'b0_0000_0010_0000,
    ST_MUL_X   = 13'b0_0000_0100_0000,
    ST_ADD_X   = 13'b0_0000_1000_0000,
    ST_MUL_Y   = 13'b0_0001_0000_0000,
    ST_ADD_Y   = 13'b0_0010_0000_0000,
    ST_START_B = 13'b0_0100_0000_0000,
    ST_WAIT_B  = 13'b0_1000_0000_0000,
    ST_OUT     = 13'b1_0000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_acc;
  logic   out_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.mul_sel = upi_pkg::MUL_D;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_o.load_in      = 1'b1;
          cmd_o.cordic_start = 1'b1;
          state_d            = ST_MUL_D;
        end
      end
      ST_MUL_D: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = upi_pkg::MUL_D;
        state_d       = ST_MUL_W;
      end
      ST_MUL_W: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = upi_pkg::MUL_W;
        state_d       = ST_MUL_K;
      end
      ST_MUL_K: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = upi_pkg::MUL_K;
        state_d       = ST_DH;
      end
      ST_DH: begin
        cmd_o.dh_en = 1'b1;
        state_d     = ST_WAIT_A;
      end
      ST_WAIT_A: begin
        if (!sts_i.cordic_busy) begin
          state_d = ST_MUL_X;
        end
      end
      ST_MUL_X: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = upi_pkg::MUL_X;
        state_d       = ST_ADD_X;
      end
      ST_ADD_X: begin
        cmd_o.add_x = 1'b1;
        state_d     = ST_MUL_Y;
      end
      ST_MUL_Y: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = upi_pkg::MUL_Y;
        state_d       = ST_ADD_Y;
      end
      ST_ADD_Y: begin
        cmd_o.add_y   = 1'b1;
        cmd_o.head_en = 1'b1;
        state_d       = ST_START_B;
      end
      ST_START_B: begin
        cmd_o.cordic_start = 1'b1;
        cmd_o.cordic_half  = 1'b1;
        state_d            = ST_WAIT_B;
      end
      ST_WAIT_B: begin
        if (!sts_i.cordic_busy) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ sim/upi_pose_checker.sv @@
// Pose predictor and result checker for the unicycle pose integrator testbench.
`timescale 1ns / 1ps

module upi_pose_checker #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  upi_pkg::in_req_t  in_req_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  upi_pkg::out_req_t out_req_i,
  output int                pending_o,
  output int                mismatch_count_o
);

  localparam int     ATAN_DEPTH   = 24;
  localparam longint START_GAIN   = 64'sd652032874;  // CORDIC gain, Q2.30
  localparam longint RAD_PER_TURN = 64'sd683565276;  // round(2^31/pi)
  localparam longint RESET_POS    = 64'sd32768;      // 0.5 m in Q16.16
  localparam longint POS_MAX      = 64'sd2147483647;
  localparam longint POS_MIN      = -64'sd2147483648;

  // atan(2^-i) in 2^-32 turn
  longint atan_step [ATAN_DEPTH] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  logic signed [31:0] x_pos;
  logic signed [31:0] y_pos;
  logic        [31:0] heading;
  upi_pkg::out_req_t  expected_poses[$];
  upi_pkg::out_req_t  want_pose;
  upi_pkg::out_req_t  new_pose;
  int                 err_total;

  function automatic longint round_shr(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // sin/cos of an angle in 2^-32 turn, Q2.30
  function automatic void cordic_sincos(input logic [31:0] ang,
                                        output longint sn, output longint cs);
    logic        flip;
    logic [31:0] a;
    longint      x, y, z, xs, ys;
    flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
    a = flip ? ang - 32'h8000_0000 : ang;  // fold into [-1/4, 1/4) turn
    z = longint'($signed(a));
    x = START_GAIN;
    y = 0;
    for (int i = 0; i < CORDIC_STAGES && i < ATAN_DEPTH; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - atan_step[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + atan_step[i];
      end
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  // Euler step: move along the old heading, then turn; builds the pose request
  task automatic advance_pose(input upi_pkg::in_req_t t, output upi_pkg::out_req_t r);
    longint speed, rate, dt, travel, sn, cs, dh;
    speed  = longint'(t.forward_speed);
    rate   = longint'(t.turn_rate);
    dt     = longint'({16'd0, t.elapsed_time});
    travel = speed * dt;  // 2^-28 m, exact
    cordic_sincos(heading, sn, cs);
    x_pos = 32'(clamp(longint'(x_pos) + round_shr(travel * cs, 42), POS_MIN, POS_MAX));
    y_pos = 32'(clamp(longint'(y_pos) + round_shr(travel * sn, 42), POS_MIN, POS_MAX));
    dh = round_shr(rate * dt * RAD_PER_TURN, 28);
    heading = heading + dh[31:0];  // wraps modulo one turn
    cordic_sincos(heading >> 1, sn, cs);
    r.pos_x         = x_pos;
    r.pos_y         = y_pos;
    r.heading_turns = heading;
    r.quat_z        = 16'(clamp(round_shr(sn, 15), -64'sd32768, 64'sd32767));
    r.quat_w        = 16'(clamp(round_shr(cs, 15), -64'sd32768, 64'sd32767));
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_total++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_pos            = 32'(RESET_POS);
      y_pos            = 32'(RESET_POS);
      heading          = '0;
      err_total        = 0;
      expected_poses.delete();
      pending_o        <= 0;
      mismatch_count_o <= 0;
    end else begin
      // retire first: a pose leaving now never belongs to a tick taken now
      if (out_valid_i && !out_stall_i) begin
        if (expected_poses.size() == 0) begin
          $error("pose request with none expected: x %0d y %0d heading %0d",
                 out_req_i.pos_x, out_req_i.pos_y, out_req_i.heading_turns);
          err_total++;
        end else begin
          want_pose = expected_poses.pop_front();
          check_field("pos_x", want_pose.pos_x, out_req_i.pos_x);
          check_field("pos_y", want_pose.pos_y, out_req_i.pos_y);
          check_field("heading_turns", longint'(want_pose.heading_turns),
                      longint'(out_req_i.heading_turns));
          check_field("quat_z", want_pose.quat_z, out_req_i.quat_z);
          check_field("quat_w", want_pose.quat_w, out_req_i.quat_w);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        advance_pose(in_req_i, new_pose);
        expected_poses.push_back(new_pose);
      end
      pending_o        <= expected_poses.size();
      mismatch_count_o <= err_total;
    end
  end

endmodule

@@ sim/unicycle_pose_integrator_tb.sv @@
// Testbench top for the unicycle pose integrator: tick stimulus, pacing and verdict.
`timescale 1ns / 1ps

module unicycle_pose_integrator_tb;

  localparam int STAGES      = 16;
  // rough accept-to-result estimate, used for the cycle limit and the drain wait
  localparam int LATENCY     = 2 * STAGES + 8;
  // a short straight full-speed run, about 8 m per tick
  localparam int DRIVE_TICKS = 16;
  localparam int RAND_TICKS  = 190;  // per idling phase
  localparam int TOTAL_TICKS = DRIVE_TICKS + 3 * RAND_TICKS + 40;
  // worst pacing is roughly latency plus sender gaps plus receiver stalls; take
  // a wide margin over that
  localparam int CYCLE_LIMIT = TOTAL_TICKS * (LATENCY + 300);

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  upi_pkg::in_req_t  in_req_i;
  logic              out_valid_o;
  logic              out_stall_i;
  upi_pkg::out_req_t out_req_o;

  int pose_pending;
  int pose_mismatches;
  int cycle_count;
  int tx_idle_pct;   // chance in 100 that the sender holds off a cycle
  int rx_stall_pct;  // chance in 100 that the receiver stalls a cycle

  unicycle_pose_integrator #(
    .CORDIC_STAGES(STAGES)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o)
  );

  upi_pose_checker #(
    .CORDIC_STAGES(STAGES)
  ) pose_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .in_req_i        (in_req_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_req_i       (out_req_o),
    .pending_o       (pose_pending),
    .mismatch_count_o(pose_mismatches)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog: a hung handshake or a lost pose ends here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: stalls at random, changes only at the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Offer one tick request: optional idle cycles, then hold it until taken.
  // Called and returning at a falling edge, so valid is set once per step.
  task automatic send_tick(input logic signed [15:0] speed,
                           input logic signed [15:0] rate,
                           input logic [15:0] dt);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i             <= 1'b1;
    in_req_i.forward_speed <= speed;
    in_req_i.turn_rate     <= rate;
    in_req_i.elapsed_time  <= dt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // one of the corner values of a signed 16-bit field
  function automatic logic [15:0] pick_extreme();
    case ($urandom_range(4))
      0:       return 16'h8000;
      1:       return 16'hFFFF;
      2:       return 16'h0000;
      3:       return 16'h0001;
      default: return 16'h7FFF;
    endcase
  endfunction

  // Random ticks: whole-range random content and plausible motion in equal shares;
  // the rest covers full-length steps that swing the pose hard, and corners.
  task automatic random_ticks(input int count);
    logic [15:0] speed, rate, dt;
    int          kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        speed = 16'($urandom);
        rate  = 16'($urandom);
        dt    = 16'($urandom);
      end else if (kind < 70) begin
        // a few milliseconds per tick, modest speed and turn
        speed = 16'($signed($urandom_range(8192)) - 4096);
        rate  = 16'($signed($urandom_range(16384)) - 8192);
        dt    = 16'($urandom_range(2000));
      end else if (kind < 85) begin
        speed = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        rate  = 16'($urandom);
        dt    = 16'($urandom_range(65535, 60000));
      end else begin
        speed = pick_extreme();
        rate  = pick_extreme();
        dt    = $urandom_range(1) ? 16'h0000 : 16'hFFFF;
      end
      send_tick(speed, rate, dt);
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_req_i     = '0;
    out_stall_i  = 1'b0;
    cycle_count  = 0;
    tx_idle_pct  = 35;
    rx_stall_pct = 60;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Heading is still zero: reverse flat out along x for a stretch, then
    // step forward again.
    for (int n = 0; n < DRIVE_TICKS; n++) send_tick(16'sh8000, 16'sh0000, 16'hFFFF);
    send_tick(16'sh8000, 16'sh0000, 16'hFFFF);
    send_tick(16'sh7FFF, 16'sh0000, 16'hFFFF);

    // zero elapsed time at the extremes: pose must not move
    send_tick(16'sh0000, 16'sh0000, 16'h0000);
    send_tick(16'sh7FFF, 16'sh7FFF, 16'h0000);
    send_tick(16'sh8000, 16'sh8000, 16'h0000);
    // full turns each way: heading wraps and the quaternion sign can flip
    send_tick(16'sh0000, 16'sh7FFF, 16'hFFFF);
    send_tick(16'sh0000, 16'sh7FFF, 16'hFFFF);
    send_tick(16'sh0000, 16'sh8000, 16'hFFFF);
    send_tick(16'sh0000, 16'sh8000, 16'hFFFF);
    send_tick(16'sh0000, 16'sh8000, 16'hFFFF);
    // smallest nonzero steps
    send_tick(16'sh0001, 16'sh0001, 16'h0001);
    send_tick(16'shFFFF, 16'shFFFF, 16'h0001);
    // full speed with the heading moving, both senses
    send_tick(16'sh7FFF, 16'sh8000, 16'hFFFF);
    send_tick(16'sh8000, 16'sh7FFF, 16'hFFFF);
    send_tick(16'sh7FFF, 16'sh4000, 16'hFFFF);
    // about a half turn (pi rad at dt = 1 s) to land near the quadrant fold
    send_tick(16'sh0000, 16'sh3244, 16'hFFFF);
    send_tick(16'sh7FFF, 16'sh0000, 16'hFFFF);
    send_tick(16'sh4000, 16'sh2000, 16'h199A);
    send_tick(16'shC000, 16'shE000, 16'h8000);

    random_ticks(RAND_TICKS);

    tx_idle_pct  = 60;
    rx_stall_pct = 35;
    random_ticks(RAND_TICKS);

    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    random_ticks(RAND_TICKS);
    in_valid_i <= 1'b0;

    // drain, then give a stray late pose time to show up
    while (pose_pending != 0) @(posedge clk_i);
    repeat (4 * LATENCY) @(posedge clk_i);

    if (pose_mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
